// ----- design/olpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpw_pkg
// Shared constants, font tables, microcode types and status bundle for the
// text line to display page packet writer.
// ----------------------------------------------------------------------------
package olpw_pkg;

    localparam int DISPLAY_WIDTH = 128;
    localparam int CHUNK_BYTES   = 7;
    localparam int PAGE_COUNT    = 8;
    localparam int GLYPH_COLS    = 6;

    localparam int PAYLOAD_W = 56;
    localparam int COUNT_W   = 3;
    localparam int PAGE_W    = 3;
    localparam int COL_CNT_W = 8;
    localparam int ADDR_W    = 7;

    localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd60;

    localparam logic [7:0] CTRL_CMD      = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam logic [7:0] FONT_DIGIT [10][5] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
    };

    localparam logic [7:0] FONT_UPPER [26][5] = '{
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
        '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
    };

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_LINE_CHK,
        STEP_CMD_PAGE,
        STEP_CMD_LO,
        STEP_CMD_HI,
        STEP_GLYPH_CHK,
        STEP_GLYPH,
        STEP_END_CHK,
        STEP_PAD_CHK,
        STEP_PAD,
        STEP_FLUSH,
        STEP_FINISH
    } step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CMD_PAGE,
        OP_CMD_LO,
        OP_CMD_HI,
        OP_GLYPH_START,
        OP_GLYPH_COL,
        OP_ZERO_COL,
        OP_FLUSH,
        OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_LINE_OPEN,
        COND_NO_ROOM,
        COND_MORE_COLS,
        COND_NOT_END,
        COND_ROW_FULL,
        COND_PAD_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic line_open;
        logic room;
        logic more_cols;
        logic row_full;
        logic pad_more;
        logic stall;
    } dp_status_t;

    // One column of a character cell; idx selects column 0..4.
    function automatic logic [7:0] glyph_column(input logic [7:0] ch,
                                                input logic [2:0] idx);
        logic [7:0] col;
        col = 8'h00;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            col = FONT_DIGIT[4'(ch - CH_ZERO)][idx];
        end else if (ch >= CH_UPA && ch <= CH_UPZ) begin
            col = FONT_UPPER[5'(ch - CH_UPA)][idx];
        end else if (ch == CH_DOT) begin
            col = (idx == 3'd1 || idx == 3'd2) ? 8'h60 : 8'h00;
        end else if (ch == CH_COLON) begin
            col = (idx == 3'd1 || idx == 3'd2) ? 8'h36 : 8'h00;
        end else if (ch == CH_DASH) begin
            col = 8'h08;
        end
        return col;
    endfunction

endpackage

// ----- design/text_line_to_oled_page_packets_unit.sv -----
`timescale 1ns / 1ps
// Steps: the idle step takes an item; a line check; on a new line the page, low
// column and high column commands; a glyph check; the column steps of a drawn
// character; an end check; on line end a pad check, zero-column pad steps that fill
// the row to DISPLAY_WIDTH columns and a flush; then a finish step. Output stalls hold the current step.
// Throughput: one item per program run; the sequencer holds one item at a time.
// Reset: synchronous active-low aresetn idles the sequencer, closes any line, address 60.
// ----------------------------------------------------------------------------
// text_line_to_oled_page_packets_unit
// Microcoded 5x7 text line writer: turns line characters into command and
// data packets for one display page.
// ----------------------------------------------------------------------------
module text_line_to_oled_page_packets_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [olpw_pkg::ADDR_W-1:0]         cfg_device_address,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_char_valid,
    input  logic [7:0]                          s_text_char,
    input  logic [olpw_pkg::PAGE_W-1:0]         s_page_index,
    input  logic                                s_line_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [olpw_pkg::ADDR_W-1:0]         m_target_address,
    output logic [7:0]                          m_control_byte,
    output logic [olpw_pkg::PAYLOAD_W-1:0]      m_payload,
    output logic [olpw_pkg::COUNT_W-1:0]        m_payload_count,
    output logic                                m_last_packet
);
    import olpw_pkg::*;

    step_t               pc_reg, pc_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic                char_valid_reg;
    logic [7:0]          text_char_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic                line_end_reg;
    ucode_t              uword;
    dp_status_t          status;
    logic                jump;

    olpw_ucode_rom u_rom (
        .step (pc_reg),
        .word (uword)
    );

    olpw_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op              (uword.op),
        .ch              (text_char_reg),
        .page            (page_reg),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_control_byte  (m_control_byte),
        .m_payload       (m_payload),
        .m_payload_count (m_payload_count),
        .m_last_packet   (m_last_packet)
    );

    assign s_ready          = (pc_reg == STEP_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_target_address = addr_reg;

    always_comb begin
        unique case (uword.cond)
            COND_NEXT:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_ITEM:   jump = !s_valid;
            COND_LINE_OPEN: jump = status.line_open;
            COND_NO_ROOM:   jump = !(char_valid_reg && status.room);
            COND_MORE_COLS: jump = status.more_cols;
            COND_NOT_END:   jump = !line_end_reg;
            COND_ROW_FULL:  jump = status.row_full;
            COND_PAD_MORE:  jump = status.pad_more;
            default:        jump = 1'b1;
        endcase
    end

    always_comb begin
        if (status.stall) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = uword.target;
        end else begin
            pc_next = step_t'(pc_reg + 4'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= STEP_IDLE;
            addr_reg <= ADDR_RESET;
        end else begin
            pc_reg <= pc_next;
            if (cfg_valid && cfg_ready) begin
                addr_reg <= cfg_device_address;
            end
        end
    end

    // Capture the word when it is taken.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_valid_reg <= s_char_valid;
            text_char_reg  <= s_text_char;
            page_reg       <= s_page_index;
            line_end_reg   <= s_line_end;
        end
    end

endmodule

// ----- design/olpw_ucode_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpw_ucode_rom
// Control store: one control word (operation, jump condition, jump target)
// per sequencer step.
// ----------------------------------------------------------------------------
module olpw_ucode_rom (
    input  olpw_pkg::step_t  step,
    output olpw_pkg::ucode_t word
);
    import olpw_pkg::*;

    always_comb begin
        unique case (step)
            STEP_IDLE:      word = '{OP_NOP,         COND_NO_ITEM,   STEP_IDLE};
            STEP_LINE_CHK:  word = '{OP_NOP,         COND_LINE_OPEN, STEP_GLYPH_CHK};
            STEP_CMD_PAGE:  word = '{OP_CMD_PAGE,    COND_NEXT,      STEP_IDLE};
            STEP_CMD_LO:    word = '{OP_CMD_LO,      COND_NEXT,      STEP_IDLE};
            STEP_CMD_HI:    word = '{OP_CMD_HI,      COND_NEXT,      STEP_IDLE};
            STEP_GLYPH_CHK: word = '{OP_GLYPH_START, COND_NO_ROOM,   STEP_END_CHK};
            STEP_GLYPH:     word = '{OP_GLYPH_COL,   COND_MORE_COLS, STEP_GLYPH};
            STEP_END_CHK:   word = '{OP_NOP,         COND_NOT_END,   STEP_FINISH};
            STEP_PAD_CHK:   word = '{OP_NOP,         COND_ROW_FULL,  STEP_FLUSH};
            STEP_PAD:       word = '{OP_ZERO_COL,    COND_PAD_MORE,  STEP_PAD};
            STEP_FLUSH:     word = '{OP_FLUSH,       COND_NEXT,      STEP_IDLE};
            STEP_FINISH:    word = '{OP_FINISH,      COND_ALWAYS,    STEP_IDLE};
            default:        word = '{OP_NOP,         COND_ALWAYS,    STEP_IDLE};
        endcase
    end

endmodule

// ----- design/olpw_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpw_datapath
// Row state, column packer, one-word staging register and output register.
// A packet is staged until the next one shows up or the item finishes, so the final
// packet of an item can carry the last flag.
// ----------------------------------------------------------------------------
module olpw_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  olpw_pkg::op_t                       op,
    input  logic [7:0]                          ch,
    input  logic [olpw_pkg::PAGE_W-1:0]         page,
    output olpw_pkg::dp_status_t                status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_control_byte,
    output logic [olpw_pkg::PAYLOAD_W-1:0]      m_payload,
    output logic [olpw_pkg::COUNT_W-1:0]        m_payload_count,
    output logic                                m_last_packet
);
    import olpw_pkg::*;

    logic                    line_open_reg, line_open_next;
    logic [COL_CNT_W-1:0]    cols_reg, cols_next;
    logic [PAYLOAD_W-1:0]    pend_reg, pend_next;
    logic [COUNT_W-1:0]      fill_reg, fill_next;
    logic [2:0]              col_idx_reg, col_idx_next;
    logic                    stage_valid_reg, stage_valid_next;
    logic [7:0]              stage_ctrl_reg;
    logic [PAYLOAD_W-1:0]    stage_payload_reg;
    logic [COUNT_W-1:0]      stage_count_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_ctrl_reg;
    logic [PAYLOAD_W-1:0]    out_payload_reg;
    logic [COUNT_W-1:0]      out_count_reg;
    logic                    out_last_reg;

    logic                    new_emit;
    logic [7:0]              new_ctrl;
    logic [PAYLOAD_W-1:0]    new_payload;
    logic [COUNT_W-1:0]      new_count;
    logic                    finish;
    logic                    stall;
    logic                    out_load;
    logic [7:0]              col_byte;
    logic [PAYLOAD_W-1:0]    pend_col;
    logic [PAGE_W-1:0]       page_sat;
    logic [COL_CNT_W:0]      cols_ext;

    assign cols_ext = {1'b0, cols_reg};
    assign page_sat = (int'(page) >= PAGE_COUNT) ? PAGE_W'(PAGE_COUNT - 1) : page;

    assign col_byte = (op == OP_GLYPH_COL && col_idx_reg != 3'(GLYPH_COLS - 1))
                    ? glyph_column(ch, col_idx_reg) : 8'h00;

    always_comb begin
        pend_col = pend_reg;
        pend_col[{fill_reg, 3'b000} +: 8] = col_byte;
    end

    always_comb begin
        line_open_next = line_open_reg;
        cols_next      = cols_reg;
        pend_next      = pend_reg;
        fill_next      = fill_reg;
        col_idx_next   = col_idx_reg;
        new_emit       = 1'b0;
        new_ctrl       = CTRL_CMD;
        new_payload    = '0;
        new_count      = COUNT_W'(1);
        finish         = 1'b0;
        unique case (op)
            OP_NOP: ;
            OP_CMD_PAGE: begin
                new_emit       = 1'b1;
                new_payload    = {48'h0, CMD_PAGE_BASE | {5'b0, page_sat}};
                line_open_next = 1'b1;
                cols_next      = '0;
                pend_next      = '0;
                fill_next      = '0;
            end
            OP_CMD_LO: begin
                new_emit    = 1'b1;
                new_payload = {48'h0, CMD_COL_LO};
            end
            OP_CMD_HI: begin
                new_emit    = 1'b1;
                new_payload = {48'h0, CMD_COL_HI};
            end
            OP_GLYPH_START: col_idx_next = '0;
            OP_GLYPH_COL, OP_ZERO_COL: begin
                cols_next = cols_reg + COL_CNT_W'(1);
                if (op == OP_GLYPH_COL) begin
                    col_idx_next = col_idx_reg + 3'd1;
                end
                if (int'(fill_reg) == CHUNK_BYTES - 1) begin
                    new_emit    = 1'b1;
                    new_ctrl    = CTRL_DATA;
                    new_payload = pend_col;
                    new_count   = COUNT_W'(CHUNK_BYTES);
                    pend_next   = '0;
                    fill_next   = '0;
                end else begin
                    pend_next = pend_col;
                    fill_next = fill_reg + COUNT_W'(1);
                end
            end
            OP_FLUSH: begin
                if (fill_reg != '0) begin
                    new_emit    = 1'b1;
                    new_ctrl    = CTRL_DATA;
                    new_payload = pend_reg;
                    new_count   = fill_reg;
                end
                line_open_next = 1'b0;
                cols_next      = '0;
                pend_next      = '0;
                fill_next      = '0;
            end
            OP_FINISH: finish = 1'b1;
            default: ;
        endcase
    end

    // Hold everything while the staged word has nowhere to go.
    assign stall    = (new_emit || finish) && stage_valid_reg && out_valid_reg && !m_ready;
    assign out_load = !stall && stage_valid_reg && (new_emit || finish);
    assign stage_valid_next = new_emit ? 1'b1 : (finish ? 1'b0 : stage_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_open_reg   <= 1'b0;
            cols_reg        <= '0;
            fill_reg        <= '0;
            col_idx_reg     <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (!stall) begin
                line_open_reg   <= line_open_next;
                cols_reg        <= cols_next;
                fill_reg        <= fill_next;
                col_idx_reg     <= col_idx_next;
                stage_valid_reg <= stage_valid_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            pend_reg <= pend_next;
        end
        if (!stall && new_emit) begin
            stage_ctrl_reg    <= new_ctrl;
            stage_payload_reg <= new_payload;
            stage_count_reg   <= new_count;
        end
        if (out_load) begin
            out_ctrl_reg    <= stage_ctrl_reg;
            out_payload_reg <= stage_payload_reg;
            out_count_reg   <= stage_count_reg;
            out_last_reg    <= finish;
        end
    end

    assign status.line_open = line_open_reg;
    assign status.room      = (cols_ext + 9'd6) <= (COL_CNT_W + 1)'(DISPLAY_WIDTH);
    assign status.more_cols = col_idx_reg != 3'(GLYPH_COLS - 1);
    assign status.row_full  = cols_ext >= (COL_CNT_W + 1)'(DISPLAY_WIDTH);
    assign status.pad_more  = (cols_ext + 9'd1) < (COL_CNT_W + 1)'(DISPLAY_WIDTH);
    assign status.stall     = stall;

    assign m_valid         = out_valid_reg;
    assign m_control_byte  = out_ctrl_reg;
    assign m_payload       = out_payload_reg;
    assign m_payload_count = out_count_reg;
    assign m_last_packet   = out_last_reg;

endmodule
